// ===== src/rgms_pkg.sv =====
// Shared types, widths and helper functions for the rigid gradient moment sum block.
// No dependencies; every other file refers to it by scoped names.
package rgms_pkg;

   localparam int MAX_DIM   = 256;
   localparam int GRAD_W    = 16;
   localparam int FRAC_W    = 4;
   localparam int SIZE_W    = 9;
   localparam int CENTER_W  = 12;
   localparam int ACC_W     = 56;
   localparam int POS_W     = $clog2(MAX_DIM);
   localparam int OFF_W     = POS_W + FRAC_W + 2;
   localparam int PROD_W    = OFF_W + GRAD_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = CENTER_W;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_X   = 3'd0,
      CSR_SIZE_Y   = 3'd1,
      CSR_SIZE_Z   = 3'd2,
      CSR_CENTER_X = 3'd3,
      CSR_CENTER_Y = 3'd4,
      CSR_CENTER_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
      logic signed [GRAD_W-1:0] grad_z;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] sum_gx;
      logic signed [ACC_W-1:0] sum_gy;
      logic signed [ACC_W-1:0] sum_gz;
      logic signed [ACC_W-1:0] moment_a;
      logic signed [ACC_W-1:0] moment_b;
      logic signed [ACC_W-1:0] moment_c;
   } rsp_type;

   typedef struct packed {
      req_type                 grad;
      logic signed [OFF_W-1:0] dx;
      logic signed [OFF_W-1:0] dy;
      logic signed [OFF_W-1:0] dz;
      logic                    last;
   } off_type;

   typedef struct packed {
      req_type                  grad;
      logic signed [PROD_W-1:0] dz_gy;
      logic signed [PROD_W-1:0] dy_gz;
      logic signed [PROD_W-1:0] dz_gx;
      logic signed [PROD_W-1:0] dx_gz;
      logic signed [PROD_W-1:0] dy_gx;
      logic signed [PROD_W-1:0] dx_gy;
      logic                     last;
   } prod_type;

   function automatic logic [POS_W-1:0] last_index(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] eff;
      if (size == '0) begin
         eff = SIZE_W'(1);
      end else if (size > SIZE_W'(MAX_DIM)) begin
         eff = SIZE_W'(MAX_DIM);
      end else begin
         eff = size;
      end
      return POS_W'(eff - SIZE_W'(1));
   endfunction

   function automatic logic signed [OFF_W-1:0] offset(input logic [POS_W-1:0] pos,
                                                     input logic [CENTER_W-1:0] center);
      return $signed({{(OFF_W-POS_W-FRAC_W){1'b0}}, pos, {FRAC_W{1'b0}}})
           - $signed({{(OFF_W-CENTER_W){1'b0}}, center});
   endfunction

   function automatic logic signed [PROD_W-1:0] mul_off_grad(
      input logic signed [OFF_W-1:0]  d,
      input logic signed [GRAD_W-1:0] g);
      logic signed [PROD_W-1:0] dw;
      logic signed [PROD_W-1:0] gw;
      dw = {{(PROD_W-OFF_W){d[OFF_W-1]}}, d};
      gw = {{(PROD_W-GRAD_W){g[GRAD_W-1]}}, g};
      return dw * gw;
   endfunction

   function automatic logic signed [ACC_W-1:0] ext_grad(input logic signed [GRAD_W-1:0] g);
      return {{(ACC_W-GRAD_W){g[GRAD_W-1]}}, g};
   endfunction

   function automatic logic signed [ACC_W-1:0] ext_prod(input logic signed [PROD_W-1:0] p);
      return {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
   endfunction

endpackage

// ===== src/rgms_ctl.sv =====
// Configuration registers, voxel position counters and offset stage.
// Depends on rgms_pkg.
module rgms_ctl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [rgms_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rgms_pkg::CSR_DAT_W-1:0]     csr_data,
   input  logic                               req_valid,
   input  rgms_pkg::req_type                  req_data,
   input  logic                               adv,
   output logic                               s1_valid,
   output rgms_pkg::off_type                  s1_data
);

   logic [rgms_pkg::SIZE_W-1:0]   size_x_ff, size_y_ff, size_z_ff;
   logic [rgms_pkg::CENTER_W-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [rgms_pkg::POS_W-1:0]    pos_x_ff, pos_y_ff, pos_z_ff;
   logic [rgms_pkg::POS_W-1:0]    pos_x_in, pos_y_in, pos_z_in;
   logic                          last_in;
   logic                          s1_valid_ff;
   rgms_pkg::off_type             s1_data_ff, s1_data_in;
   logic                          accept;

   assign accept = req_valid & adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff   <= rgms_pkg::SIZE_RESET;
         size_y_ff   <= rgms_pkg::SIZE_RESET;
         size_z_ff   <= rgms_pkg::SIZE_RESET;
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            rgms_pkg::CSR_SIZE_X:   size_x_ff   <= csr_data[rgms_pkg::SIZE_W-1:0];
            rgms_pkg::CSR_SIZE_Y:   size_y_ff   <= csr_data[rgms_pkg::SIZE_W-1:0];
            rgms_pkg::CSR_SIZE_Z:   size_z_ff   <= csr_data[rgms_pkg::SIZE_W-1:0];
            rgms_pkg::CSR_CENTER_X: center_x_ff <= csr_data;
            rgms_pkg::CSR_CENTER_Y: center_y_ff <= csr_data;
            rgms_pkg::CSR_CENTER_Z: center_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      last_in  = 1'b0;
      if (pos_x_ff >= rgms_pkg::last_index(size_x_ff)) begin
         pos_x_in = '0;
         if (pos_y_ff >= rgms_pkg::last_index(size_y_ff)) begin
            pos_y_in = '0;
            if (pos_z_ff >= rgms_pkg::last_index(size_z_ff)) begin
               pos_z_in = '0;
               last_in  = 1'b1;
            end else begin
               pos_z_in = pos_z_ff + {{(rgms_pkg::POS_W-1){1'b0}}, 1'b1};
            end
         end else begin
            pos_y_in = pos_y_ff + {{(rgms_pkg::POS_W-1){1'b0}}, 1'b1};
         end
      end else begin
         pos_x_in = pos_x_ff + {{(rgms_pkg::POS_W-1){1'b0}}, 1'b1};
      end
   end

   always_comb begin
      s1_data_in.grad = req_data;
      s1_data_in.dx   = rgms_pkg::offset(pos_x_ff, center_x_ff);
      s1_data_in.dy   = rgms_pkg::offset(pos_y_ff, center_y_ff);
      s1_data_in.dz   = rgms_pkg::offset(pos_z_ff, center_z_ff);
      s1_data_in.last = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         pos_z_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
         if (accept) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
            pos_z_ff <= pos_z_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= s1_data_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_data_ff;

endmodule

// ===== src/rgms_mul.sv =====
// Product stage: six offset-by-gradient products, registered.
// Depends on rgms_pkg.
module rgms_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                s1_valid,
   input  rgms_pkg::off_type   s1_data,
   output logic                s2_valid,
   output rgms_pkg::prod_type  s2_data
);

   logic                s2_valid_ff;
   rgms_pkg::prod_type  s2_data_ff, s2_data_in;

   always_comb begin
      s2_data_in.grad  = s1_data.grad;
      s2_data_in.dz_gy = rgms_pkg::mul_off_grad(s1_data.dz, s1_data.grad.grad_y);
      s2_data_in.dy_gz = rgms_pkg::mul_off_grad(s1_data.dy, s1_data.grad.grad_z);
      s2_data_in.dz_gx = rgms_pkg::mul_off_grad(s1_data.dz, s1_data.grad.grad_x);
      s2_data_in.dx_gz = rgms_pkg::mul_off_grad(s1_data.dx, s1_data.grad.grad_z);
      s2_data_in.dy_gx = rgms_pkg::mul_off_grad(s1_data.dy, s1_data.grad.grad_x);
      s2_data_in.dx_gy = rgms_pkg::mul_off_grad(s1_data.dx, s1_data.grad.grad_y);
      s2_data_in.last  = s1_data.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_data  = s2_data_ff;

endmodule

// ===== src/rgms_acc.sv =====
// Accumulator stage and result register; generates the pipeline advance.
// Depends on rgms_pkg.
module rgms_acc (
   input  logic                clock,
   input  logic                reset,
   input  logic                s2_valid,
   input  rgms_pkg::prod_type  s2_data,
   output logic                adv,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rgms_pkg::rsp_type   rsp_data
);

   rgms_pkg::rsp_type  acc_ff, acc_in;
   rgms_pkg::rsp_type  rsp_data_ff;
   logic               rsp_valid_ff;
   logic               step;

   // hold everything only when a finished volume meets a blocked result register
   assign adv  = !(rsp_valid_ff && rsp_stall && s2_valid && s2_data.last);
   assign step = adv & s2_valid;

   always_comb begin
      acc_in.sum_gx   = acc_ff.sum_gx + rgms_pkg::ext_grad(s2_data.grad.grad_x);
      acc_in.sum_gy   = acc_ff.sum_gy + rgms_pkg::ext_grad(s2_data.grad.grad_y);
      acc_in.sum_gz   = acc_ff.sum_gz + rgms_pkg::ext_grad(s2_data.grad.grad_z);
      acc_in.moment_a = acc_ff.moment_a + rgms_pkg::ext_prod(s2_data.dy_gz)
                      - rgms_pkg::ext_prod(s2_data.dz_gy);
      acc_in.moment_b = acc_ff.moment_b + rgms_pkg::ext_prod(s2_data.dx_gz)
                      - rgms_pkg::ext_prod(s2_data.dz_gx);
      acc_in.moment_c = acc_ff.moment_c + rgms_pkg::ext_prod(s2_data.dx_gy)
                      - rgms_pkg::ext_prod(s2_data.dy_gx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (step) begin
         acc_ff <= s2_data.last ? '0 : acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && s2_data.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && s2_data.last) begin
         rsp_data_ff <= acc_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/rigid_gradient_moment_sum_top.sv =====
// The result is offered once the last voxel has passed the offset and product registers.
// Throughput: 1 voxel per cycle through the offset, product and accumulate stages, but
// the input stalls only while a result waits in the result register and the next
// volume's last voxel reaches the accumulate stage.
// Reset (synchronous) clears counters, accumulators and valid bits, and restores the
// registers to size 256 and center 0. Depends on rgms_pkg, rgms_ctl, rgms_mul, rgms_acc.
module rigid_gradient_moment_sum_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rgms_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rgms_pkg::CSR_DAT_W-1:0]      csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rgms_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rgms_pkg::rsp_type                   rsp_data
);

   logic                adv;
   logic                s1_valid, s2_valid;
   rgms_pkg::off_type   s1_data;
   rgms_pkg::prod_type  s2_data;

   assign csr_ready = 1'b1;
   assign req_stall = !adv;

   rgms_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_data  (req_data),
      .adv       (adv),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data)
   );

   rgms_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .s1_valid (s1_valid),
      .s1_data  (s1_data),
      .s2_valid (s2_valid),
      .s2_data  (s2_data)
   );

   rgms_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .s2_valid  (s2_valid),
      .s2_data   (s2_data),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
